[design/expression_token_lexer_core_defines.svh]
// assertion macros shared by the lexer rtl
`ifndef EXPRESSION_TOKEN_LEXER_CORE_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define ETLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define ETLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/etl_pkg.sv]
// types, codes and character helpers of the expression token lexer
`timescale 1ns / 1ps

package etl_pkg;

    // lexer mode kept between items
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STAR,
        MODE_IDENT,
        MODE_STRING
    } etl_mode_t;

    // emission sequencer state
    typedef enum logic [1:0] {
        ST_INPUT,
        ST_EMIT_A,
        ST_FLUSH,
        ST_EMIT_B
    } etl_state_t;

    // token kinds
    localparam logic [2:0] KIND_OP     = 3'd0;
    localparam logic [2:0] KIND_ASSIGN = 3'd1;
    localparam logic [2:0] KIND_SEP    = 3'd2;
    localparam logic [2:0] KIND_LPAR   = 3'd3;
    localparam logic [2:0] KIND_RPAR   = 3'd4;
    localparam logic [2:0] KIND_STR    = 3'd5;
    localparam logic [2:0] KIND_ID     = 3'd6;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;

    // one result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       has_char;
        logic       tok_start;
        logic       tok_end;
        logic       ovf;
        logic       last;
    } etl_result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // characters that form a one-character token on their own
    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SLASH) || (c == CH_EQ) ||
               (c == CH_COLON) || (c == CH_SEMI) || (c == CH_LPAR) || (c == CH_RPAR);
    endfunction

    function automatic logic [2:0] single_kind(input logic [7:0] c);
        logic [2:0] k;
        k = KIND_OP;
        case (c) inside
            CH_EQ:           k = KIND_ASSIGN;
            CH_COLON, CH_SEMI: k = KIND_SEP;
            CH_LPAR:         k = KIND_LPAR;
            CH_RPAR:         k = KIND_RPAR;
            default:         k = KIND_OP;
        endcase
        return k;
    endfunction

    function automatic etl_result_t make_res(input logic [2:0] kind, input logic [7:0] ch,
                                             input logic has_char, input logic tok_start,
                                             input logic tok_end, input logic ovf,
                                             input logic last);
        etl_result_t r;
        r.kind      = kind;
        r.ch        = ch;
        r.has_char  = has_char;
        r.tok_start = tok_start;
        r.tok_end   = tok_end;
        r.ovf       = ovf;
        r.last      = last;
        return r;
    endfunction

endpackage

[design/etl_ident_mem.sv]
// identifier byte buffer: one write port, one registered read port
`timescale 1ns / 1ps

module etl_ident_mem #(
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/etl_out_stage.sv]
// output register of the result channel, packs one result per beat
`timescale 1ns / 1ps

module etl_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  etl_pkg::etl_result_t push_res,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // char_out, token_start, token_end, id_overflow
    output logic [3:0]           m_tuser,   // token_kind, has_char
    output logic                 m_tlast
);
    import etl_pkg::*;

    logic        valid_reg;
    etl_result_t res_reg;

    // register is free when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    // beat packing
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, res_reg.ovf, res_reg.tok_end, res_reg.tok_start, res_reg.ch};
    assign m_tuser  = {res_reg.has_char, res_reg.kind};
    assign m_tlast  = res_reg.last;

endmodule

[design/expression_token_lexer_core.sv]
// expression token lexer: top level with mode state and emission sequencer
//
// Usage: source bytes arrive on the s_ channel, one per beat; a beat with
// s_tlast high marks end of input (its byte is ignored) and closes any open
// token. Token characters leave on the m_ channel, one per beat, with the
// kind and has_char in m_tuser and the character plus start, end and
// overflow marks in m_tdata; m_tlast marks the last result of an input beat.
// Alphanumeric runs are written into the identifier memory as they arrive
// (at most ID_BUF_LEN bytes) and replayed one byte per clock while the
// output register is free, through its single registered read port.
// Results: a beat yields at most ID_BUF_LEN + 1 results, held in the
// sequencer registers until the output register takes them.
// Reset: mode returns to idle, the sequencer to input, and run length,
// replay index and run flags clear; the pending result payload is not reset
// and the identifier memory is not cleared, entries are only read after being
// written. Stalls: a held output beat stops the replay sequencer, s_tready
// stays low until every result of the current beat has been handed to the
// output register, which itself separates the two channels.
`timescale 1ns / 1ps
`include "expression_token_lexer_core_defines.svh"

module expression_token_lexer_core #(
    parameter int ID_BUF_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_out, token_start, token_end, id_overflow
    output logic [3:0]  m_tuser,   // token_kind, has_char
    output logic        m_tlast    // run_last
);
    import etl_pkg::*;

    localparam int ADDR_W = $clog2(ID_BUF_LEN);
    localparam int LEN_W  = $clog2(ID_BUF_LEN + 1);
    localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(ID_BUF_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_THREE = LEN_W'(3);

    etl_state_t       state_reg, state_next;
    etl_mode_t        mode_reg, mode_next;
    logic [LEN_W-1:0] ident_len_reg, ident_len_next;
    logic             ident_trunc_reg, ident_trunc_next;
    logic             kw_and_reg, kw_and_next;
    logic             kw_or_reg, kw_or_next;
    logic             kw_not_reg, kw_not_next;
    logic             str_chars_reg, str_chars_next;
    logic             b_valid_reg, b_valid_next;
    logic [LEN_W-1:0] flush_idx_reg, flush_idx_next;
    etl_result_t      a_res_reg, a_res_next;
    etl_result_t      b_res_reg, b_res_next;
    logic [LEN_W-1:0] flush_len_reg, flush_len_next;
    logic [2:0]       flush_kind_reg, flush_kind_next;
    logic             flush_ovf_reg, flush_ovf_next;

    logic              accept;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    logic              push;
    etl_result_t       push_res;
    logic              out_free;
    logic              is_kw;
    logic              flush_last;

    assign s_tready = (state_reg == ST_INPUT);
    assign accept   = s_tvalid && s_tready;

    // keyword match from the prefix flags gathered while the run was written
    assign is_kw = !ident_trunc_reg &&
                   (((ident_len_reg == LEN_THREE) && (kw_and_reg || kw_not_reg)) ||
                    ((ident_len_reg == LEN_TWO) && kw_or_reg));

    assign flush_last = ((flush_idx_reg + LEN_ONE) == flush_len_reg);

    etl_ident_mem #(
        .DEPTH (ID_BUF_LEN)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    etl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INPUT;
            mode_reg        <= MODE_IDLE;
            ident_len_reg   <= '0;
            ident_trunc_reg <= 1'b0;
            kw_and_reg      <= 1'b0;
            kw_or_reg       <= 1'b0;
            kw_not_reg      <= 1'b0;
            str_chars_reg   <= 1'b0;
            b_valid_reg     <= 1'b0;
            flush_idx_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            ident_len_reg   <= ident_len_next;
            ident_trunc_reg <= ident_trunc_next;
            kw_and_reg      <= kw_and_next;
            kw_or_reg       <= kw_or_next;
            kw_not_reg      <= kw_not_next;
            str_chars_reg   <= str_chars_next;
            b_valid_reg     <= b_valid_next;
            flush_idx_reg   <= flush_idx_next;
        end
    end

    // pending result payload
    always_ff @(posedge clk)
    begin
        a_res_reg      <= a_res_next;
        b_res_reg      <= b_res_next;
        flush_len_reg  <= flush_len_next;
        flush_kind_reg <= flush_kind_next;
        flush_ovf_reg  <= flush_ovf_next;
    end

    // item decode and result sequencing
    always_comb
    begin
        logic a_v;
        logic b_v;
        logic do_flush;
        logic run_idle;

        a_v      = 1'b0;
        b_v      = 1'b0;
        do_flush = 1'b0;
        run_idle = 1'b0;

        state_next       = state_reg;
        mode_next        = mode_reg;
        ident_len_next   = ident_len_reg;
        ident_trunc_next = ident_trunc_reg;
        kw_and_next      = kw_and_reg;
        kw_or_next       = kw_or_reg;
        kw_not_next      = kw_not_reg;
        str_chars_next   = str_chars_reg;
        b_valid_next     = b_valid_reg;
        flush_idx_next   = flush_idx_reg;
        a_res_next       = a_res_reg;
        b_res_next       = b_res_reg;
        flush_len_next   = flush_len_reg;
        flush_kind_next  = flush_kind_reg;
        flush_ovf_next   = flush_ovf_reg;

        mem_we    = 1'b0;
        mem_waddr = ident_len_reg[ADDR_W-1:0];
        mem_re    = 1'b0;
        mem_raddr = '0;
        push      = 1'b0;
        push_res  = b_res_reg;

        unique case (state_reg)
            ST_INPUT:
            begin
                if (accept)
                begin
                    if (s_tlast)
                    begin
                        // end of input closes whatever is open
                        mode_next      = MODE_IDLE;
                        str_chars_next = 1'b0;
                        unique case (mode_reg)
                            MODE_IDLE:
                            begin
                            end
                            MODE_STAR:
                            begin
                                b_v        = 1'b1;
                                b_res_next = make_res(KIND_OP, CH_STAR, 1'b1, 1'b1, 1'b1,
                                                      1'b0, 1'b1);
                            end
                            MODE_IDENT:
                            begin
                                do_flush = 1'b1;
                            end
                            MODE_STRING:
                            begin
                                b_v        = 1'b1;
                                b_res_next = make_res(KIND_STR, CH_NUL, 1'b0, !str_chars_reg,
                                                      1'b1, 1'b0, 1'b1);
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_IDLE:
                            begin
                                run_idle = 1'b1;
                            end
                            MODE_STAR:
                            begin
                                a_v = 1'b1;
                                if (s_tdata == CH_STAR)
                                begin
                                    a_res_next = make_res(KIND_OP, CH_STAR, 1'b1, 1'b1, 1'b0,
                                                          1'b0, 1'b0);
                                    b_v        = 1'b1;
                                    b_res_next = make_res(KIND_OP, CH_STAR, 1'b1, 1'b0, 1'b1,
                                                          1'b0, 1'b1);
                                    mode_next  = MODE_IDLE;
                                end
                                else
                                begin
                                    a_res_next = make_res(KIND_OP, CH_STAR, 1'b1, 1'b1, 1'b1,
                                                          1'b0, 1'b0);
                                    run_idle   = 1'b1;
                                end
                            end
                            MODE_IDENT:
                            begin
                                if (is_alnum(s_tdata))
                                begin
                                    if (ident_len_reg < BUF_LEN)
                                    begin
                                        mem_we         = 1'b1;
                                        ident_len_next = ident_len_reg + LEN_ONE;
                                        // keyword prefix tracking
                                        if (ident_len_reg == LEN_ONE)
                                        begin
                                            kw_and_next = kw_and_reg && (s_tdata == CH_LC_N);
                                            kw_or_next  = kw_or_reg && (s_tdata == CH_LC_R);
                                            kw_not_next = kw_not_reg && (s_tdata == CH_LC_O);
                                        end
                                        else if (ident_len_reg == LEN_TWO)
                                        begin
                                            kw_and_next = kw_and_reg && (s_tdata == CH_LC_D);
                                            kw_or_next  = 1'b0;
                                            kw_not_next = kw_not_reg && (s_tdata == CH_LC_T);
                                        end
                                    end
                                    else
                                    begin
                                        ident_trunc_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    do_flush = 1'b1;
                                    run_idle = 1'b1;
                                end
                            end
                            MODE_STRING:
                            begin
                                b_v = 1'b1;
                                if (s_tdata == CH_QUOTE)
                                begin
                                    b_res_next     = make_res(KIND_STR, CH_NUL, 1'b0,
                                                              !str_chars_reg, 1'b1, 1'b0, 1'b1);
                                    str_chars_next = 1'b0;
                                    mode_next      = MODE_IDLE;
                                end
                                else
                                begin
                                    b_res_next     = make_res(KIND_STR, s_tdata, 1'b1,
                                                              !str_chars_reg, 1'b0, 1'b0, 1'b1);
                                    str_chars_next = 1'b1;
                                end
                            end
                        endcase
                    end

                    // latch the buffered run and start its replay at entry zero
                    if (do_flush)
                    begin
                        flush_len_next   = ident_len_reg;
                        flush_kind_next  = is_kw ? KIND_OP : KIND_ID;
                        flush_ovf_next   = ident_trunc_reg;
                        flush_idx_next   = '0;
                        mem_re           = 1'b1;
                        mem_raddr        = '0;
                        ident_len_next   = '0;
                        ident_trunc_next = 1'b0;
                        mode_next        = MODE_IDLE;
                    end

                    // a byte seen with no token open
                    if (run_idle)
                    begin
                        mode_next = MODE_IDLE;
                        if (s_tdata == CH_QUOTE)
                        begin
                            mode_next      = MODE_STRING;
                            str_chars_next = 1'b0;
                        end
                        else if (is_alnum(s_tdata))
                        begin
                            mode_next        = MODE_IDENT;
                            mem_we           = 1'b1;
                            mem_waddr        = '0;
                            ident_len_next   = LEN_ONE;
                            ident_trunc_next = 1'b0;
                            kw_and_next      = (s_tdata == CH_LC_A);
                            kw_or_next       = (s_tdata == CH_LC_O);
                            kw_not_next      = (s_tdata == CH_LC_N);
                        end
                        else if (s_tdata == CH_STAR)
                        begin
                            mode_next = MODE_STAR;
                        end
                        else if (is_single(s_tdata))
                        begin
                            b_v        = 1'b1;
                            b_res_next = make_res(single_kind(s_tdata), s_tdata, 1'b1, 1'b1,
                                                  1'b1, 1'b0, 1'b1);
                        end
                    end

                    b_valid_next = b_v;
                    if (a_v)
                    begin
                        state_next = ST_EMIT_A;
                    end
                    else if (do_flush)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (b_v)
                    begin
                        state_next = ST_EMIT_B;
                    end
                end
            end
            ST_EMIT_A:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    push_res      = a_res_reg;
                    push_res.last = !b_valid_reg;
                    state_next    = b_valid_reg ? ST_EMIT_B : ST_INPUT;
                end
            end
            ST_FLUSH:
            begin
                // read data of entry flush_idx is waiting in the memory register
                if (out_free)
                begin
                    push     = 1'b1;
                    push_res = make_res(flush_kind_reg, mem_rdata, 1'b1,
                                        (flush_idx_reg == '0), flush_last, flush_ovf_reg,
                                        flush_last && !b_valid_reg);
                    if (flush_last)
                    begin
                        state_next = b_valid_reg ? ST_EMIT_B : ST_INPUT;
                    end
                    else
                    begin
                        mem_re         = 1'b1;
                        flush_idx_next = flush_idx_reg + LEN_ONE;
                        mem_raddr      = flush_idx_next[ADDR_W-1:0];
                    end
                end
            end
            ST_EMIT_B:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_res   = b_res_reg;
                    state_next = ST_INPUT;
                end
            end
        endcase
    end

    `ETLC_ASSERT_NOW(a_push_free, push, out_free,
        "result pushed while the output register is held")
    `ETLC_ASSERT_NOW(a_flush_range, state_reg == ST_FLUSH, flush_idx_reg < flush_len_reg,
        "identifier replay index beyond the run length")
    `ETLC_ASSERT_NOW(a_len_bound, mode_reg == MODE_IDENT,
        (ident_len_reg != '0) && (ident_len_reg <= BUF_LEN),
        "identifier length out of range while a run is open")
    `ETLC_ASSERT_NEXT(a_trunc_set,
        accept && !s_tlast && (mode_reg == MODE_IDENT) && is_alnum(s_tdata) &&
        (ident_len_reg == BUF_LEN),
        ident_trunc_reg && (ident_len_reg == BUF_LEN),
        "overlong identifier not flagged as truncated")

endmodule

[tb/sv/expression_token_lexer_core_test.sv]
// self-checking testbench for the expression token lexer core
`timescale 1ns / 1ps

module expression_token_lexer_core_test;
    import etl_pkg::*;

    localparam int IDENT_CAP   = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_GOAL = 310;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HIGH  = 8'hFF;
    localparam logic [7:0] CH_STRAY = 8'h80;

    // one expected token character as it leaves the block
    typedef struct {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       has_char;
        logic       tok_start;
        logic       tok_end;
        logic       ovf;
        logic       last;
    } lexeme_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // char_out, token_start, token_end, id_overflow
    logic [3:0]  m_tuser;   // token_kind, has_char
    logic        m_tlast;   // run_last

    // lexer state mirrored on the testbench side
    etl_mode_t    lex_state = MODE_IDLE;
    logic [7:0]   ident_chars [IDENT_CAP];
    int           ident_len = 0;
    logic         ident_trunc = 1'b0;
    logic         str_has_text = 1'b0;
    lexeme_beat_t beat_tokens[$];
    lexeme_beat_t pending_beats[$];

    int fail_count  = 0;
    int sent_items  = 0;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    expression_token_lexer_core #(
        .ID_BUF_LEN(IDENT_CAP)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #10 clk = ~clk;

    // watchdog on cycles where neither side moves a beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_punct(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_SLASH || c == CH_EQ ||
               c == CH_COLON || c == CH_SEMI || c == CH_LPAR || c == CH_RPAR;
    endfunction

    task automatic emit(input logic [2:0] kind, input logic [7:0] ch, input logic has,
                        input logic st, input logic en, input logic ovf);
        lexeme_beat_t b;
        b.kind      = kind;
        b.ch        = ch;
        b.has_char  = has;
        b.tok_start = st;
        b.tok_end   = en;
        b.ovf       = ovf;
        b.last      = 1'b0;
        beat_tokens.push_back(b);
    endtask

    // replay buffered run as identifier or word operator
    task automatic replay_ident();
        logic [2:0] kind;
        bit         word_op;
        int         i;
        word_op = 1'b0;
        if (!ident_trunc)
        begin
            if (ident_len == 3 && ident_chars[0] == CH_LC_A && ident_chars[1] == CH_LC_N &&
                ident_chars[2] == CH_LC_D)
                word_op = 1'b1;
            if (ident_len == 2 && ident_chars[0] == CH_LC_O && ident_chars[1] == CH_LC_R)
                word_op = 1'b1;
            if (ident_len == 3 && ident_chars[0] == CH_LC_N && ident_chars[1] == CH_LC_O &&
                ident_chars[2] == CH_LC_T)
                word_op = 1'b1;
        end
        kind = word_op ? KIND_OP : KIND_ID;
        for (i = 0; i < ident_len; i++)
            emit(kind, ident_chars[i], 1'b1, i == 0, i == ident_len - 1, ident_trunc);
        ident_len   = 0;
        ident_trunc = 1'b0;
        lex_state   = MODE_IDLE;
    endtask

    // a byte seen with no token open
    task automatic open_token(input logic [7:0] c);
        lex_state = MODE_IDLE;
        case (c)
            CH_QUOTE:
            begin
                lex_state    = MODE_STRING;
                str_has_text = 1'b0;
            end
            CH_STAR:                     lex_state = MODE_STAR;
            CH_PLUS, CH_MINUS, CH_SLASH: emit(KIND_OP, c, 1'b1, 1'b1, 1'b1, 1'b0);
            CH_EQ:                       emit(KIND_ASSIGN, c, 1'b1, 1'b1, 1'b1, 1'b0);
            CH_COLON, CH_SEMI:           emit(KIND_SEP, c, 1'b1, 1'b1, 1'b1, 1'b0);
            CH_LPAR:                     emit(KIND_LPAR, c, 1'b1, 1'b1, 1'b1, 1'b0);
            CH_RPAR:                     emit(KIND_RPAR, c, 1'b1, 1'b1, 1'b1, 1'b0);
            default:
            begin
                if (is_word_char(c))
                begin
                    lex_state      = MODE_IDENT;
                    ident_chars[0] = c;
                    ident_len      = 1;
                    ident_trunc    = 1'b0;
                end
            end
        endcase
    endtask

    // work out the token beats that one accepted input beat causes
    task automatic lex_beat(input logic [7:0] c, input logic eoi);
        lexeme_beat_t tail;
        beat_tokens.delete();
        if (eoi)
        begin
            case (lex_state)
                MODE_STAR:   emit(KIND_OP, CH_STAR, 1'b1, 1'b1, 1'b1, 1'b0);
                MODE_IDENT:  replay_ident();
                MODE_STRING: emit(KIND_STR, CH_NUL, 1'b0, !str_has_text, 1'b1, 1'b0);
                default:     ;
            endcase
            lex_state    = MODE_IDLE;
            str_has_text = 1'b0;
        end
        else
        begin
            case (lex_state)
                MODE_STAR:
                begin
                    if (c == CH_STAR)
                    begin
                        emit(KIND_OP, CH_STAR, 1'b1, 1'b1, 1'b0, 1'b0);
                        emit(KIND_OP, CH_STAR, 1'b1, 1'b0, 1'b1, 1'b0);
                        lex_state = MODE_IDLE;
                    end
                    else
                    begin
                        emit(KIND_OP, CH_STAR, 1'b1, 1'b1, 1'b1, 1'b0);
                        open_token(c);
                    end
                end
                MODE_IDENT:
                begin
                    if (is_word_char(c))
                    begin
                        if (ident_len < IDENT_CAP)
                        begin
                            ident_chars[ident_len] = c;
                            ident_len++;
                        end
                        else
                            ident_trunc = 1'b1;
                    end
                    else
                    begin
                        replay_ident();
                        open_token(c);
                    end
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        emit(KIND_STR, CH_NUL, 1'b0, !str_has_text, 1'b1, 1'b0);
                        str_has_text = 1'b0;
                        lex_state    = MODE_IDLE;
                    end
                    else
                    begin
                        emit(KIND_STR, c, 1'b1, !str_has_text, 1'b0, 1'b0);
                        str_has_text = 1'b1;
                    end
                end
                default: open_token(c);
            endcase
        end
        // last beat of this input carries run_last
        if (beat_tokens.size() > 0)
        begin
            tail = beat_tokens.pop_back();
            tail.last = 1'b1;
            beat_tokens.push_back(tail);
        end
        while (beat_tokens.size() > 0)
            pending_beats.push_back(beat_tokens.pop_front());
    endtask

    // drive one input beat and predict its results on acceptance
    task automatic send_beat(input logic [7:0] c, input logic eoi, input bit counted);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        do @(posedge clk); while (!s_tready);
        lex_beat(c, eoi);
        if (counted)
            sent_items++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_beat(c, 1'b0, 1'b1);
    endtask

    task automatic send_eoi();
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] rand_word_char();
        int idx;
        idx = $urandom_range(0, 61);
        if (idx < 10)
            return 8'(8'h30 + idx);
        else if (idx < 36)
            return 8'(8'h41 + idx - 10);
        return 8'(8'h61 + idx - 36);
    endfunction

    // one-character tokens of every kind
    task automatic test_single_tokens();
        send_char(CH_PLUS);
        send_char(CH_MINUS);
        send_char(CH_SLASH);
        send_char(CH_EQ);
        send_char(CH_COLON);
        send_char(CH_SEMI);
        send_char(CH_LPAR);
        send_char(CH_RPAR);
    endtask

    // double star as one operator, then a lone star ended by a paren
    task automatic test_star_pairs();
        send_char(CH_STAR);
        send_char(CH_STAR);
        send_char(CH_STAR);
        send_char(CH_LPAR);
    endtask

    // word operators, empty string, odd string bytes, string closed by end of input
    task automatic test_keywords_and_strings();
        send_text("and");
        send_char(CH_SPACE);
        send_text("not");
        send_char(CH_QUOTE);
        send_char(CH_QUOTE);
        send_char(CH_QUOTE);
        send_char(CH_NUL);
        send_char(CH_HIGH);
        send_eoi();
    endtask

    // random token streams with noise and occasional end of input
    task automatic test_random_expressions();
        int          len;
        logic [7:0]  c;
        while (sent_items < RANDOM_GOAL)
        begin
            if ($urandom_range(0, 39) == 0)
                steady = ~steady;
            case ($urandom_range(0, 15))
                0, 1, 2:
                begin
                    len = ($urandom_range(0, 7) == 0) ?
                          $urandom_range(IDENT_CAP - 2, IDENT_CAP + 6) : $urandom_range(1, 6);
                    repeat (len) send_char(rand_word_char());
                end
                3:
                begin
                    case ($urandom_range(0, 5))
                        0: send_text("and");
                        1: send_text("or");
                        2: send_text("not");
                        3: send_text("AND");
                        4: send_text("nota");
                        default: send_text("no");
                    endcase
                end
                4, 5:
                begin
                    do c = 8'($urandom_range(0, 255)); while (!is_punct(c));
                    send_char(c);
                end
                6:
                begin
                    send_char(CH_STAR);
                    if ($urandom_range(0, 1) == 1)
                        send_char(CH_STAR);
                end
                7, 8:
                begin
                    send_char(CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                        send_char(c);
                    end
                    if ($urandom_range(0, 7) != 0)
                        send_char(CH_QUOTE);
                end
                9:
                begin
                    case ($urandom_range(0, 2))
                        0: send_beat(CH_SPACE, 1'b0, 1'b0);
                        1: send_beat(CH_LF, 1'b0, 1'b0);
                        default: send_beat(CH_CR, 1'b0, 1'b0);
                    endcase
                end
                10:
                begin
                    // bytes the lexer skips outside strings
                    do c = 8'($urandom_range(0, 255));
                    while (is_word_char(c) || is_punct(c) || c == CH_QUOTE || c == CH_STAR);
                    send_beat(c, 1'b0, 1'b0);
                end
                11: send_eoi();
                12, 13:
                begin
                    repeat ($urandom_range(1, 4)) send_char(8'(8'h30 + $urandom_range(0, 9)));
                end
                default: send_char(8'($urandom_range(0, 255)));
            endcase
        end
        steady = 1'b0;
        send_beat(CH_STRAY, 1'b0, 1'b0);
        send_eoi();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls, compare each beat with the oldest expectation
    initial
    begin
        lexeme_beat_t want;
        int           stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_beats.size() == 0)
            begin
                $error("token beat with nothing expected: tdata %h tuser %h tlast %b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("token_kind", int'(want.kind), int'(m_tuser[2:0]));
                check_field("char_out", int'(want.ch), int'(m_tdata[7:0]));
                check_field("has_char", int'(want.has_char), int'(m_tuser[3]));
                check_field("token_start", int'(want.tok_start), int'(m_tdata[8]));
                check_field("token_end", int'(want.tok_end), int'(m_tdata[9]));
                check_field("id_overflow", int'(want.ovf), int'(m_tdata[10]));
                check_field("run_last", int'(want.last), int'(m_tlast));
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_tokens();
        test_star_pairs();
        test_keywords_and_strings();
        test_random_expressions();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[expression_token_lexer_core.f]
+incdir+design
design/etl_pkg.sv
design/etl_ident_mem.sv
design/etl_out_stage.sv
design/expression_token_lexer_core.sv
tb/sv/expression_token_lexer_core_test.sv
